[rtl/assert_macros.svh]
// Assertion macros for the RTL of the 3x3 matrix inverse, used by matrix3_inverse.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/m3i_pkg.sv]
// Package for the 3x3 matrix inverse: default widths, cofactor index table,
// stage control struct. Depends on nothing.
`default_nettype none
package m3i_pkg;
	localparam int M3I_WORD_BITS = 32;
	localparam int M3I_FRAC_BITS = 16;
	localparam int M3I_ELEMS     = 9;

	// Cofactor i = a[c0]*a[c1] - a[c2]*a[c3], row-major element indexes.
	localparam int unsigned M3I_COF [M3I_ELEMS][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	typedef struct packed {
		logic load;
		logic valid;
	} m3i_ctl_t;
endpackage
`default_nettype wire

[rtl/m3i_in_if.sv]
// Input channel of the matrix inverse: valid, ready and nine matrix elements.
// Depends on m3i_pkg.
`default_nettype none
interface m3i_in_if import m3i_pkg::*; #(
	parameter int WORD_BITS = M3I_WORD_BITS
);
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
		output ready);
endinterface
`default_nettype wire

[rtl/m3i_out_if.sv]
// Output channel of the matrix inverse: valid, ready, nine elements, singular.
// Depends on m3i_pkg.
`default_nettype none
interface m3i_out_if import m3i_pkg::*; #(
	parameter int WORD_BITS = M3I_WORD_BITS
);
	logic valid;
	logic ready;
	logic signed [WORD_BITS-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic singular;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		singular, output ready);
endinterface
`default_nettype wire

[rtl/m3i_div_step.sv]
// One restoring-division stage for all nine lanes, with its pipeline register.
// Depends on m3i_pkg.
`default_nettype none
module m3i_div_step import m3i_pkg::*; #(
	parameter int RW = 8,
	parameter int QB = 4,
	parameter int DBW = 8,
	parameter int MW = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire m3i_ctl_t            ctl,
	input  wire logic [RW+QB-1:0]    x_in [M3I_ELEMS],
	input  wire logic [DBW-1:0]      d_in,
	input  wire logic [MW-1:0]       meta_in,
	output logic [RW+QB-1:0]         x_out [M3I_ELEMS],
	output logic [DBW-1:0]           d_out,
	output logic [MW-1:0]            meta_out,
	output logic                     valid_out
);
	logic [RW+QB-1:0] x_nxt [M3I_ELEMS];
	logic [RW-1:0]    cand  [M3I_ELEMS];
	logic [RW-1:0]    dv;
	logic [RW+QB-1:0] x_s1 [M3I_ELEMS];
	logic [DBW-1:0]   d_s1;
	logic [MW-1:0]    meta_s1;
	logic             v_s1;

	// Shift one dividend bit into the remainder, subtract where it fits.
	always_comb begin
		dv = RW'(d_in);
		for (int i = 0; i < M3I_ELEMS; i++) begin
			cand[i] = x_in[i][RW+QB-2:QB-1];
			if (cand[i] >= dv) begin
				x_nxt[i] = {cand[i] - dv, x_in[i][QB-2:0], 1'b1};
			end else begin
				x_nxt[i] = {cand[i], x_in[i][QB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctl.load) begin
			v_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_s1    <= x_nxt;
			d_s1    <= d_in;
			meta_s1 <= meta_in;
		end
	end

	assign x_out     = x_s1;
	assign d_out     = d_s1;
	assign meta_out  = meta_s1;
	assign valid_out = v_s1;
endmodule
`default_nettype wire

[rtl/matrix3_inverse.sv]
// 3x3 matrix inverse, signed fixed point, adjugate over determinant.
// Throughput: one matrix per cycle while the skid register is empty; set by the fully pipelined datapath.
// One restoring-division stage per quotient bit (WORD_BITS + 1 of them).
// Reset clears the valid bits of every stage and the output skid register;
// payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module matrix3_inverse import m3i_pkg::*; #(
	parameter int WORD_BITS = M3I_WORD_BITS,
	parameter int FRAC_BITS = M3I_FRAC_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	m3i_in_if.sink    mat,
	m3i_out_if.source inv
);
	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int AW  = 2 * W + 1;          // adjugate entry
	localparam int DW  = 3 * W + 3;          // determinant
	localparam int QB  = W + 1;              // quotient bits
	localparam int NSH = 2 * F + 1;          // dividend shift
	localparam int NA  = AW + NSH;
	localparam int NW  = ((NA > DW) ? NA : DW) + 1;
	localparam int RW  = DW + 2;             // remainder
	localparam int XW  = RW + QB;
	localparam int MW  = 2 * M3I_ELEMS + 1;  // sign, overflow, singular
	localparam logic [QB-1:0] QPOS = (QB'(1) << (W - 1)) - QB'(1);
	localparam logic [QB-1:0] QNEG = QB'(1) << (W - 1);
	localparam logic [W-1:0] ONE_W = (F < W - 1) ? (W'(1) << F) : {1'b0, {(W-1){1'b1}}};

	logic en;
	logic signed [W-1:0] a_in [M3I_ELEMS];

	// Stage registers.
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s10;
	logic signed [2*W-1:0] p_s1 [M3I_ELEMS];
	logic signed [2*W-1:0] m_s1 [M3I_ELEMS];
	logic signed [W-1:0]   a_s1 [3];
	logic signed [W-1:0]   a_s2 [3];
	logic signed [AW-1:0]  adj_s2 [M3I_ELEMS];
	logic signed [AW-1:0]  adj_s3 [M3I_ELEMS];
	logic signed [AW-1:0]  adj_s4 [M3I_ELEMS];
	logic signed [AW-1:0]  adj_s5 [M3I_ELEMS];
	logic signed [2*W:0]   plo_s3 [3];
	logic signed [2*W:0]   phi_s3 [3];
	logic signed [DW-1:0]  term_s4 [3];
	logic signed [DW-1:0]  det_s5;
	logic [DW-1:0]         dmag_s6;
	logic [AW-1:0]         amag_s6 [M3I_ELEMS];
	logic [M3I_ELEMS-1:0]  aneg_s6;
	logic                  dneg_s6, dz_s6;
	logic [NW-1:0]         n_s7 [M3I_ELEMS];
	logic [DW:0]           d_s7;
	logic [M3I_ELEMS-1:0]  sg_s7;
	logic                  dz_s7;
	logic [XW-1:0]         x_s8 [M3I_ELEMS];
	logic [DW:0]           d_s8;
	logic [M3I_ELEMS-1:0]  sg_s8, ovf_s8;
	logic                  dz_s8;

	// Division chain: entry 0 is stage 8, entry k the output of step k.
	logic [XW-1:0] x_s9 [QB+1][M3I_ELEMS];
	logic [DW:0]   d_s9 [QB+1];
	logic [MW-1:0] meta_s9 [QB+1];
	logic          v_s9 [QB+1];
	m3i_ctl_t      ctl_s9 [QB];

	logic [W-1:0] res_s10 [M3I_ELEMS];
	logic         sing_s10;

	// Skid register on the output side.
	logic [W-1:0] res_q [M3I_ELEMS];
	logic         sing_q, skid_v_q;

	logic [W-1:0]  res_c [M3I_ELEMS];
	logic [QB-1:0] q_c   [M3I_ELEMS];
	logic [QB-1:0] lim_c [M3I_ELEMS];
	logic [QB-1:0] mag_c [M3I_ELEMS];
	logic          neg_c [M3I_ELEMS];
	logic [M3I_ELEMS-1:0] sg_f, ovf_f;
	logic          dz_f;
	logic [DW-1:0] det_u;
	logic [AW-1:0] adj_u [M3I_ELEMS];

	assign a_in[0] = mat.a00;
	assign a_in[1] = mat.a01;
	assign a_in[2] = mat.a02;
	assign a_in[3] = mat.a10;
	assign a_in[4] = mat.a11;
	assign a_in[5] = mat.a12;
	assign a_in[6] = mat.a20;
	assign a_in[7] = mat.a21;
	assign a_in[8] = mat.a22;

	// Advance the whole pipeline unless the skid register holds a result.
	assign en        = !skid_v_q;
	assign mat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1 <= mat.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s10 <= v_s9[QB];
		end
	end

	always_comb begin
		det_u = det_s5;
		for (int i = 0; i < M3I_ELEMS; i++) begin
			adj_u[i] = adj_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: the two products of every cofactor.
			for (int i = 0; i < M3I_ELEMS; i++) begin
				p_s1[i] <= a_in[M3I_COF[i][0]] * a_in[M3I_COF[i][1]];
				m_s1[i] <= a_in[M3I_COF[i][2]] * a_in[M3I_COF[i][3]];
			end
			for (int k = 0; k < 3; k++) begin
				a_s1[k] <= a_in[k];
			end
			// Stage 2: adjugate entries.
			for (int i = 0; i < M3I_ELEMS; i++) begin
				adj_s2[i] <= AW'(p_s1[i]) - AW'(m_s1[i]);
			end
			a_s2 <= a_s1;
			// Stage 3: first-row expansion, split into low and high partial products.
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= a_s2[k] * $signed({1'b0, adj_s2[3*k][W-1:0]});
				phi_s3[k] <= a_s2[k] * $signed(adj_s2[3*k][AW-1:W]);
			end
			adj_s3 <= adj_s2;
			// Stage 4: recombine the partial products.
			for (int k = 0; k < 3; k++) begin
				term_s4[k] <= (DW'(phi_s3[k]) <<< W) + DW'(plo_s3[k]);
			end
			adj_s4 <= adj_s3;
			// Stage 5: determinant.
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			adj_s5 <= adj_s4;
			// Stage 6: magnitudes and signs.
			dz_s6   <= (det_u == '0);
			dneg_s6 <= det_u[DW-1];
			dmag_s6 <= det_u[DW-1] ? ('0 - det_u) : det_u;
			for (int i = 0; i < M3I_ELEMS; i++) begin
				aneg_s6[i] <= adj_u[i][AW-1];
				amag_s6[i] <= adj_u[i][AW-1] ? ('0 - adj_u[i]) : adj_u[i];
			end
			// Stage 7: rounding dividend and doubled divisor.
			for (int i = 0; i < M3I_ELEMS; i++) begin
				n_s7[i]  <= (NW'(amag_s6[i]) << NSH) + NW'(dmag_s6);
				sg_s7[i] <= aneg_s6[i] ^ dneg_s6;
			end
			d_s7  <= {dmag_s6, 1'b0};
			dz_s7 <= dz_s6;
			// Stage 8: overflow check and initial remainder.
			for (int i = 0; i < M3I_ELEMS; i++) begin
				ovf_s8[i] <= (n_s7[i] >> QB) >= NW'(d_s7);
				x_s8[i]   <= {RW'(n_s7[i] >> QB), n_s7[i][QB-1:0]};
			end
			d_s8  <= d_s7;
			sg_s8 <= sg_s7;
			dz_s8 <= dz_s7;
			// Stage 10: saturated result, identity when singular.
			res_s10  <= res_c;
			sing_s10 <= dz_f;
		end
	end

	always_comb begin
		x_s9[0]    = x_s8;
		d_s9[0]    = d_s8;
		meta_s9[0] = {sg_s8, ovf_s8, dz_s8};
		v_s9[0]    = v_s8;
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		assign ctl_s9[k] = '{load: en, valid: v_s9[k]};
		m3i_div_step #(
			.RW (RW),
			.QB (QB),
			.DBW(DW + 1),
			.MW (MW)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_s9[k]),
			.x_in     (x_s9[k]),
			.d_in     (d_s9[k]),
			.meta_in  (meta_s9[k]),
			.x_out    (x_s9[k+1]),
			.d_out    (d_s9[k+1]),
			.meta_out (meta_s9[k+1]),
			.valid_out(v_s9[k+1])
		);
	end

	// Sign, saturate, or drop to identity on a zero determinant.
	always_comb begin
		{sg_f, ovf_f, dz_f} = meta_s9[QB];
		for (int i = 0; i < M3I_ELEMS; i++) begin
			q_c[i]   = x_s9[QB][i][QB-1:0];
			neg_c[i] = sg_f[i] && (q_c[i] != '0);
			lim_c[i] = neg_c[i] ? QNEG : QPOS;
			mag_c[i] = (ovf_f[i] || (q_c[i] > lim_c[i])) ? lim_c[i] : q_c[i];
			if (dz_f) begin
				res_c[i] = (i == 0 || i == 4 || i == 8) ? ONE_W : '0;
			end else if (neg_c[i]) begin
				res_c[i] = '0 - mag_c[i][W-1:0];
			end else begin
				res_c[i] = mag_c[i][W-1:0];
			end
		end
	end

	// Hold a result that was not taken while the pipeline moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en && v_s10 && !inv.ready) begin
			skid_v_q <= 1'b1;
		end else if (skid_v_q && inv.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s10 && !inv.ready) begin
			res_q  <= res_s10;
			sing_q <= sing_s10;
		end
	end

	assign inv.valid    = skid_v_q || v_s10;
	assign inv.r00      = skid_v_q ? res_q[0] : res_s10[0];
	assign inv.r01      = skid_v_q ? res_q[1] : res_s10[1];
	assign inv.r02      = skid_v_q ? res_q[2] : res_s10[2];
	assign inv.r10      = skid_v_q ? res_q[3] : res_s10[3];
	assign inv.r11      = skid_v_q ? res_q[4] : res_s10[4];
	assign inv.r12      = skid_v_q ? res_q[5] : res_s10[5];
	assign inv.r20      = skid_v_q ? res_q[6] : res_s10[6];
	assign inv.r21      = skid_v_q ? res_q[7] : res_s10[7];
	assign inv.r22      = skid_v_q ? res_q[8] : res_s10[8];
	assign inv.singular = skid_v_q ? sing_q : sing_s10;

	`ASSERT_IMPLIES(a_sing_identity, inv.valid && inv.singular,
		(inv.r00 == ONE_W) && (inv.r11 == ONE_W) && (inv.r22 == ONE_W) && (inv.r01 == '0))
	`ASSERT_NEXT(a_skid_fill, en && v_s10 && !inv.ready, skid_v_q)
	`ASSERT_NEXT(a_skid_hold, skid_v_q && !inv.ready, skid_v_q && $stable(sing_q))
endmodule
`default_nettype wire

[verif/tb_matrix3_inverse.sv]
// Testbench for matrix3_inverse: directed table then random 3x3 matrices, each result checked
// against a typed expectation or an exact adjugate-over-determinant predictor.
// Depends on m3i_pkg, m3i_in_if, m3i_out_if and matrix3_inverse.
`default_nettype none
module tb_matrix3_inverse;
	import m3i_pkg::*;

	localparam int W         = M3I_WORD_BITS;
	localparam int FB        = M3I_FRAC_BITS;
	localparam int N_RANDOM  = 700;
	localparam int QUIET_TAIL = 80;   // last transfers run with no idling
	localparam int HOLD_CYC  = 400;   // long receiver hold-off, fills the pipe
	localparam int DRAIN_CYC = 60;    // margin after the last expected result
	localparam int LIMIT_CYC = 300000;

	localparam logic signed [W-1:0] Q_ONE = 1 <<< FB;
	localparam logic signed [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

	// Cofactor i = e[c0]*e[c1] - e[c2]*e[c3], row-major element indexes.
	localparam int COFAC [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	// Wide enough for exact determinants and shifted numerators (~2^98).
	typedef logic signed [191:0] wide_t;
	typedef logic signed [W-1:0] elem_t;

	typedef struct {
		elem_t e [9];
	} mat_t;

	typedef struct {
		elem_t e [9];
		logic  singular;
	} inverse_t;

	// A pending item: the typed expectation where there is one.
	typedef struct {
		mat_t     m;
		bit       typed;
		inverse_t want;
	} row_t;

	logic clk;
	logic arst_n;

	m3i_in_if  mat_ch ();
	m3i_out_if inv_ch ();

	matrix3_inverse dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat_ch),
		.inv    (inv_ch)
	);

	inverse_t expected_inv_q [$];
	row_t     typed_q [$];    // set by the sender, popped on input transfer
	row_t     stim_q [$];
	int       n_in_xfer;
	int       n_total;
	int       n_errors;
	int       cycles;
	bit       hold_done;

	// Exact inverse: adjugate times 2^(2*FB) over determinant, rounded half
	// away from zero, saturated to the word. Zero determinant gives identity.
	function automatic inverse_t invert3(mat_t m);
		wide_t    a [9];
		wide_t    adj [9];
		wide_t    det, dmag, num, quo;
		logic     dneg, nneg;
		inverse_t r;
		for (int i = 0; i < 9; i++) begin
			a[i] = m.e[i];
		end
		for (int i = 0; i < 9; i++) begin
			adj[i] = a[COFAC[i][0]] * a[COFAC[i][1]] - a[COFAC[i][2]] * a[COFAC[i][3]];
		end
		det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
		if (det == 0) begin
			foreach (r.e[i]) r.e[i] = '0;
			r.e[0] = Q_ONE;
			r.e[4] = Q_ONE;
			r.e[8] = Q_ONE;
			r.singular = 1'b1;
			return r;
		end
		dneg = det < 0;
		dmag = dneg ? -det : det;
		for (int i = 0; i < 9; i++) begin
			nneg = adj[i] < 0;
			num = ((nneg ? -adj[i] : adj[i]) <<< (2 * FB + 1)) + dmag;
			quo = num / (dmag <<< 1);
			if ((nneg ^ dneg) && quo != 0) begin
				r.e[i] = (quo > (wide_t'(1) <<< (W - 1))) ? Q_MIN : elem_t'(-quo);
			end else begin
				r.e[i] = (quo > wide_t'(Q_MAX)) ? Q_MAX : elem_t'(quo);
			end
		end
		r.singular = 1'b0;
		return r;
	endfunction

	function automatic inverse_t diag_inverse(elem_t v, logic sing);
		inverse_t r;
		foreach (r.e[i]) r.e[i] = '0;
		r.e[0] = v;
		r.e[4] = v;
		r.e[8] = v;
		r.singular = sing;
		return r;
	endfunction

	function automatic mat_t diag_mat(elem_t v);
		mat_t m;
		foreach (m.e[i]) m.e[i] = '0;
		m.e[0] = v;
		m.e[4] = v;
		m.e[8] = v;
		return m;
	endfunction

	function automatic mat_t fill_mat(elem_t v);
		mat_t m;
		foreach (m.e[i]) m.e[i] = v;
		return m;
	endfunction

	function automatic elem_t small_fixed();
		// roughly -4.0 .. +4.0 with a random fraction
		return elem_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	function automatic elem_t corner_value();
		case ($urandom_range(0, 5))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return elem_t'(1);
			4: return elem_t'(-1);
			default: return elem_t'($urandom);
		endcase
	endfunction

	// Mostly well-conditioned small matrices; the rest full-range noise,
	// singular by construction, or built from corner values.
	function automatic mat_t random_mat();
		mat_t m;
		int   kind;
		kind = $urandom_range(0, 9);
		foreach (m.e[i]) begin
			case (kind)
				0, 1, 2: m.e[i] = elem_t'($urandom);
				9:       m.e[i] = corner_value();
				default: m.e[i] = small_fixed();
			endcase
		end
		if (kind == 7) begin
			// copy row 0 into row 2: determinant exactly zero
			m.e[6] = m.e[0];
			m.e[7] = m.e[1];
			m.e[8] = m.e[2];
		end else if (kind == 8) begin
			// strong diagonal: inverse lands well inside range
			m.e[0] = m.e[0] + (elem_t'(8) <<< FB);
			m.e[4] = m.e[4] - (elem_t'(8) <<< FB);
			m.e[8] = m.e[8] + (elem_t'(8) <<< FB);
		end
		return m;
	endfunction

	task automatic add_row(mat_t m, bit typed, inverse_t want);
		row_t r;
		r.m = m;
		r.typed = typed;
		r.want = want;
		stim_q.push_back(r);
	endtask

	// Directed table: rows with a typed result are read off directly,
	// the rest go through the predictor.
	task automatic build_directed();
		inverse_t none;
		mat_t     m;
		none = diag_inverse('0, 1'b0);
		add_row(fill_mat('0), 1, diag_inverse(Q_ONE, 1'b1));
		add_row(diag_mat(Q_ONE), 1, diag_inverse(Q_ONE, 1'b0));
		add_row(diag_mat(-Q_ONE), 1, diag_inverse(-Q_ONE, 1'b0));
		add_row(diag_mat(Q_ONE <<< 1), 1, diag_inverse(Q_ONE >>> 1, 1'b0));
		add_row(fill_mat(Q_MIN), 1, diag_inverse(Q_ONE, 1'b1));
		add_row(fill_mat(Q_MAX), 1, diag_inverse(Q_ONE, 1'b1));
		// one-LSB diagonal: inverse far beyond range, saturate both ways
		add_row(diag_mat(elem_t'(1)), 1, diag_inverse(Q_MAX, 1'b0));
		add_row(diag_mat(elem_t'(-1)), 1, diag_inverse(Q_MIN, 1'b0));
		add_row(diag_mat(Q_MAX), 0, none);
		add_row(diag_mat(Q_MIN), 0, none);
		add_row(fill_mat(elem_t'(32'h5555_5555)), 1, diag_inverse(Q_ONE, 1'b1));
		m = diag_mat(Q_ONE);
		m.e[1] = elem_t'(32'hAAAA_AAAA);
		m.e[5] = elem_t'(32'h5555_5555);
		add_row(m, 0, none);
		// zero column: singular
		m = random_mat();
		m.e[2] = '0;
		m.e[5] = '0;
		m.e[8] = '0;
		add_row(m, 1, diag_inverse(Q_ONE, 1'b1));
		// equal rows: singular
		m = random_mat();
		m.e[3] = m.e[0];
		m.e[4] = m.e[1];
		m.e[5] = m.e[2];
		add_row(m, 1, diag_inverse(Q_ONE, 1'b1));
		// round-half cases: 3.0 and 3-LSB diagonals
		add_row(diag_mat(Q_ONE * 3), 0, none);
		add_row(diag_mat(elem_t'(3)), 0, none);
		m = fill_mat(elem_t'(-1));
		m.e[0] = Q_MIN;
		m.e[4] = Q_MAX;
		add_row(m, 0, none);
		for (int i = 0; i < 4; i++) begin
			add_row(random_mat(), 0, none);
		end
	endtask

	task automatic drive_mat(mat_t m);
		mat_ch.a00 <= m.e[0];
		mat_ch.a01 <= m.e[1];
		mat_ch.a02 <= m.e[2];
		mat_ch.a10 <= m.e[3];
		mat_ch.a11 <= m.e[4];
		mat_ch.a12 <= m.e[5];
		mat_ch.a20 <= m.e[6];
		mat_ch.a21 <= m.e[7];
		mat_ch.a22 <= m.e[8];
	endtask

	function automatic bit quiet_phase();
		return n_in_xfer >= n_total - QUIET_TAIL;
	endfunction

	// Clock: period 4.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle limit: fail if the run hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYC) begin
			$display("tb_matrix3_inverse failed");
			$finish;
		end
	end

	// Input transfer: compute the expected inverse from the values just taken.
	always @(posedge clk) begin
		row_t     r;
		inverse_t exp_inv;
		mat_t     m;
		if (arst_n && mat_ch.valid && mat_ch.ready) begin
			m.e = '{mat_ch.a00, mat_ch.a01, mat_ch.a02, mat_ch.a10, mat_ch.a11,
				mat_ch.a12, mat_ch.a20, mat_ch.a21, mat_ch.a22};
			r = typed_q.pop_front();
			exp_inv = r.typed ? r.want : invert3(m);
			expected_inv_q.push_back(exp_inv);
			n_in_xfer <= n_in_xfer + 1;
		end
	end

	// Output transfer: compare field by field against the oldest expectation.
	always @(posedge clk) begin
		inverse_t got, want;
		string    names [9];
		names = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
		if (arst_n && inv_ch.valid && inv_ch.ready) begin
			got.e = '{inv_ch.r00, inv_ch.r01, inv_ch.r02, inv_ch.r10, inv_ch.r11,
				inv_ch.r12, inv_ch.r20, inv_ch.r21, inv_ch.r22};
			got.singular = inv_ch.singular;
			if (expected_inv_q.size() == 0) begin
				$error("unexpected result transfer, nothing pending");
				n_errors++;
			end else begin
				want = expected_inv_q.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (got.e[i] !== want.e[i]) begin
						$error("%s: expected %0d, got %0d", names[i], want.e[i], got.e[i]);
						n_errors++;
					end
				end
				if (got.singular !== want.singular) begin
					$error("singular: expected %0b, got %0b", want.singular, got.singular);
					n_errors++;
				end
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off while the sender keeps
	// offering, and a clean stretch at the end.
	initial begin
		int stall_left;
		stall_left = 0;
		inv_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet_phase()) begin
				inv_ch.ready <= 1'b1;
			end else if (!hold_done && n_in_xfer >= 150) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYC - 1;
				inv_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				inv_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				inv_ch.ready <= 1'b0;
			end else begin
				inv_ch.ready <= 1'b1;
			end
		end
	end

	// Sender and end of run.
	initial begin
		row_t r;
		int   gap;
		mat_t zero_m;
		zero_m = fill_mat('0);
		n_in_xfer = 0;
		n_errors = 0;
		cycles = 0;
		hold_done = 1'b0;
		mat_ch.valid = 1'b0;
		mat_ch.a00 = '0; mat_ch.a01 = '0; mat_ch.a02 = '0;
		mat_ch.a10 = '0; mat_ch.a11 = '0; mat_ch.a12 = '0;
		mat_ch.a20 = '0; mat_ch.a21 = '0; mat_ch.a22 = '0;
		arst_n = 1'b0;

		build_directed();
		for (int i = 0; i < N_RANDOM; i++) begin
			add_row(random_mat(), 0, diag_inverse('0, 1'b0));
		end
		n_total = stim_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Each pass starts at a falling edge: right after reset release, or
		// right after the previous item was transferred.
		foreach (stim_q[k]) begin
			// idle burst before this item, never in the final stretch
			gap = (!quiet_phase() && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
			if (gap > 0) begin
				mat_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			r = stim_q[k];
			typed_q.push_back(r);
			drive_mat(r.m);
			mat_ch.valid <= 1'b1;
			// hold the item until it is transferred
			do @(negedge clk); while (n_in_xfer <= k);
			if (k == n_total - 1) begin
				mat_ch.valid <= 1'b0;
				drive_mat(zero_m);
			end
		end

		while (expected_inv_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);

		if (expected_inv_q.size() != 0) begin
			$error("%0d expected results never arrived", expected_inv_q.size());
			n_errors++;
		end
		if (n_errors == 0) begin
			$display("tb_matrix3_inverse passed");
		end else begin
			$display("tb_matrix3_inverse failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
